// ===== src/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the nearest-distance reduce block.
// They compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that expr never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/lmdr_pkg.sv =====
// ============================================================================
// lmdr_pkg
// Widths, register indexes and item types of the nearest-distance reduce.
// ============================================================================
`default_nettype none

package lmdr_pkg;

    localparam int COORD_BITS     = 16;
    localparam int SQ_BITS        = 2 * COORD_BITS + 2;
    localparam int DIST_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * COORD_BITS;
    localparam int REM_BITS       = DIST_BITS + 1;
    localparam int ITER_BITS      = $clog2(DIST_BITS);
    localparam int CFG_INDEX_BITS = 8;
    localparam int QDEPTH         = 4;
    localparam int QPTR_BITS      = $clog2(QDEPTH);
    localparam int QCNT_BITS      = QPTR_BITS + 1;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic [SQ_BITS-1:0]        sq_t;
    typedef logic [DIST_BITS-1:0]      dist_t;

    localparam cfg_index_t REG_QUERY_X = cfg_index_t'(0);
    localparam cfg_index_t REG_QUERY_Y = cfg_index_t'(1);
    localparam cfg_index_t REG_QUERY_Z = cfg_index_t'(2);
    localparam cfg_index_t REG_QUERY_W = cfg_index_t'(3);

    typedef struct packed {
        coord_t     point_x;
        coord_t     point_y;
        coord_t     point_z;
        coord_t     point_w;
        sq_t        prior_min_sq;
        logic       first_point;
        logic       last_point;
    } point_t;

    typedef struct packed {
        sq_t        min_sq;
        dist_t      min_dist;
    } result_t;

    typedef struct packed {
        logic                 empty;
        logic [QCNT_BITS-1:0] level;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== src/lmdr_front.sv =====
// ============================================================================
// lmdr_front
// Query registers, distance pipeline and running minimum; queues run minima.
// ============================================================================
`default_nettype none

module lmdr_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  lmdr_pkg::cfg_index_t   cfg_index,
    input  lmdr_pkg::coord_t       cfg_data,
    input  logic                   push,
    output logic                   full,
    input  lmdr_pkg::point_t       point,
    input  lmdr_pkg::q_stat_t      q_stat,
    output logic                   q_wr,
    output lmdr_pkg::sq_t          q_wr_data
);
    import lmdr_pkg::*;

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    coord_t                  qx_reg, qy_reg, qz_reg, qw_reg;
    logic                    accept;

    logic                    s1_valid_reg, s1_first_reg, s1_last_reg;
    coord_t                  s1_diff_reg [4];
    sq_t                     s1_prior_reg;

    logic                    s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [PROD_BITS-1:0]    s2_sq_reg [4];
    sq_t                     s2_prior_reg;

    logic                    s3_valid_reg, s3_first_reg, s3_last_reg;
    sq_t                     s3_sum_reg;
    sq_t                     s3_prior_reg;

    sq_t                     run_min_reg, run_min_next;
    sq_t                     cur_min, new_min;
    logic [QCNT_BITS:0]      pending;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
            qw_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_QUERY_X: qx_reg <= cfg_data;
                REG_QUERY_Y: qy_reg <= cfg_data;
                REG_QUERY_Z: qz_reg <= cfg_data;
                REG_QUERY_W: qw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold input while queue slots are promised to run ends in flight.
    always_comb
    begin
        pending = (QCNT_BITS+1)'(q_stat.level)
                + (QCNT_BITS+1)'(s1_valid_reg & s1_last_reg)
                + (QCNT_BITS+1)'(s2_valid_reg & s2_last_reg)
                + (QCNT_BITS+1)'(s3_valid_reg & s3_last_reg);
        full = (pending >= (QCNT_BITS+1)'(QDEPTH));
    end

    assign accept = push && !full;

    always_comb
    begin
        cur_min      = s3_first_reg ? s3_prior_reg : run_min_reg;
        new_min      = (s3_sum_reg < cur_min) ? s3_sum_reg : cur_min;
        run_min_next = s3_valid_reg ? new_min : run_min_reg;
        q_wr         = s3_valid_reg && s3_last_reg;
        q_wr_data    = new_min;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            run_min_reg  <= '1;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            run_min_reg  <= run_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg[0] <= abs_diff(point.point_x, qx_reg);
        s1_diff_reg[1] <= abs_diff(point.point_y, qy_reg);
        s1_diff_reg[2] <= abs_diff(point.point_z, qz_reg);
        s1_diff_reg[3] <= abs_diff(point.point_w, qw_reg);
        s1_prior_reg   <= point.prior_min_sq;
        s1_first_reg   <= point.first_point;
        s1_last_reg    <= point.last_point;

        // Widen both operands so the square keeps all of its bits.
        for (int i = 0; i < 4; i++)
        begin
            s2_sq_reg[i] <= PROD_BITS'(s1_diff_reg[i]) * PROD_BITS'(s1_diff_reg[i]);
        end
        s2_prior_reg <= s1_prior_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;

        s3_sum_reg   <= SQ_BITS'(s2_sq_reg[0]) + SQ_BITS'(s2_sq_reg[1])
                      + SQ_BITS'(s2_sq_reg[2]) + SQ_BITS'(s2_sq_reg[3]);
        s3_prior_reg <= s2_prior_reg;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
    end

endmodule

`default_nettype wire

// ===== src/lmdr_queue.sv =====
// ============================================================================
// lmdr_queue
// Short queue of finished run minima between the front and the root unit.
// ============================================================================
`default_nettype none

module lmdr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  lmdr_pkg::sq_t       wr_data,
    input  logic                rd_en,
    output lmdr_pkg::sq_t       rd_data,
    output lmdr_pkg::q_stat_t   stat
);
    import lmdr_pkg::*;

    sq_t                    mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]   level_reg, level_next;

    always_comb
    begin
        level_next = level_reg;
        if (wr_en && !rd_en)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem_reg[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.empty = (level_reg == '0);

endmodule

`default_nettype wire

// ===== src/lmdr_back.sv =====
// ============================================================================
// lmdr_back
// Bit-pair floor square root of each run minimum and the result register.
// ============================================================================
`default_nettype none

module lmdr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lmdr_pkg::q_stat_t   q_stat,
    input  lmdr_pkg::sq_t       q_rd_data,
    output logic                q_rd,
    output logic                empty,
    input  logic                pop,
    output lmdr_pkg::result_t   result
);
    import lmdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(DIST_BITS - 1);

    state_t                 state_reg, state_next;
    logic [ITER_BITS-1:0]   cnt_reg, cnt_next;
    sq_t                    val_reg, val_next;
    sq_t                    sq_reg, sq_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    dist_t                  root_reg, root_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic [REM_BITS+1:0]    rem_try;
    logic [REM_BITS+1:0]    trial;
    logic                   take;
    logic                   load_out;

    always_comb
    begin
        rem_try = {rem_reg, val_reg[SQ_BITS-1 -: 2]};
        trial   = (REM_BITS+2)'({root_reg, 2'b01});
        take    = (rem_try >= trial);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        sq_next        = sq_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        out_next       = out_reg;
        q_rd           = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_rd       = 1'b1;
                    val_next   = q_rd_data;
                    sq_next    = q_rd_data;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                rem_next  = take ? REM_BITS'(rem_try - trial) : REM_BITS'(rem_try);
                root_next = {root_reg[DIST_BITS-2:0], take};
                val_next  = {val_reg[SQ_BITS-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out         = 1'b1;
                    out_next.min_sq   = sq_reg;
                    out_next.min_dist = root_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        out_reg  <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

// ===== src/leaf_min_distance_reduce.sv =====
// ----------------------------------------------------------------------------
// Usage:
// Write the query point through the cfg channel (index 0..3 for x, y, z, w;
// other indexes are ignored). cfg_ready is always high; write only while the
// block is idle.
// Push leaf points with push/full. The first point of a run loads the prior
// best square, the last point produces one request on the result side.
// Throughput: one point per cycle while full is low. From the last point's
// push to empty falling, a run end passes 3 distance stages, one queue write,
// then the root unit (a load step, 17 iterations of one bit pair each, and a
// hand-over to the result register).
// The root unit handles one run end at a time; up to 4 run minima wait
// in the queue in front of it, and full rises when those slots are spoken
// for by queued and in-flight run ends.
// When the receiver stalls, the result is held and one more finished run
// waits in the root unit; the queue then fills and full holds the input.
// Reset clears the query to zero, the running minimum to all ones and
// empties every stage. No clearing pass is needed.
// ----------------------------------------------------------------------------
// ============================================================================
// leaf_min_distance_reduce
// Running minimum of squared 4-D distances over leaf runs, with floor root.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module leaf_min_distance_reduce (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lmdr_pkg::cfg_index_t  cfg_index,
    input  lmdr_pkg::coord_t      cfg_data,
    input  logic                  push,
    output logic                  full,
    input  lmdr_pkg::point_t      point,
    output logic                  empty,
    input  logic                  pop,
    output lmdr_pkg::result_t     result
);
    import lmdr_pkg::*;

    logic       q_wr;
    logic       q_rd;
    sq_t        q_wr_data;
    sq_t        q_rd_data;
    q_stat_t    q_stat;

    // Configuration writes are always accepted.
    assign cfg_ready = 1'b1;

    // Front: query registers, distance pipeline, running minimum.
    lmdr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .point     (point),
        .q_stat    (q_stat),
        .q_wr      (q_wr),
        .q_wr_data (q_wr_data)
    );

    // Decouple the point stream from the multi-cycle root unit.
    lmdr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // Back: floor square root and the result register.
    lmdr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_rd_data (q_rd_data),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // The full flag must reserve a slot for every run end in flight.
    `ASSERT_NEVER(a_q_overflow, clk, rst_n, q_wr && !q_rd && (q_stat.level == QCNT_BITS'(QDEPTH)), "run minimum written into a full queue")
    // The root unit must only take a run minimum that is there.
    `ASSERT_NEVER(a_q_underflow, clk, rst_n, q_rd && q_stat.empty, "root unit read an empty queue")
    // Queue fill moves by at most one entry per cycle.
    `ASSERT_NEXT(a_q_level_step, clk, rst_n, 1'b1, (q_stat.level == $past(q_stat.level)) || (q_stat.level == $past(q_stat.level) + 1'b1) || (q_stat.level == $past(q_stat.level) - 1'b1), "queue level jumped")

endmodule

`default_nettype wire

// ===== tb/leaf_min_distance_reduce_checker.sv =====
// ============================================================================
// leaf_min_distance_reduce_checker
// Watches the config, point and result channels of the nearest-distance
// reduce, predicts each run minimum and its floor root, and counts mismatches.
// ============================================================================
module leaf_min_distance_reduce_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  lmdr_pkg::cfg_index_t cfg_index,
    input  lmdr_pkg::coord_t     cfg_data,
    input  logic                 push,
    input  logic                 full,
    input  lmdr_pkg::point_t     point,
    input  logic                 empty,
    input  logic                 pop,
    input  lmdr_pkg::result_t    result,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lmdr_pkg::*;

    coord_t  query_x;
    coord_t  query_y;
    coord_t  query_z;
    coord_t  query_w;
    sq_t     best_sq;
    result_t run_min_due[$];
    result_t due;
    sq_t     cand_sq;
    sq_t     keep_sq;

    function automatic logic [63:0] sq_of_diff(coord_t a, coord_t b);
        logic [63:0] d;
        d = (a >= b) ? 64'(a - b) : 64'(b - a);
        return d * d;
    endfunction

    function automatic sq_t point_dist_sq(point_t p);
        logic [63:0] acc;
        acc = sq_of_diff(p.point_x, query_x) + sq_of_diff(p.point_y, query_y)
            + sq_of_diff(p.point_z, query_z) + sq_of_diff(p.point_w, query_w);
        return sq_t'(acc);
    endfunction

    // Bitwise floor root: set each root bit from the top if its square fits.
    function automatic dist_t isqrt_floor(sq_t v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= 64'(v))
                root = trial;
        end
        return dist_t'(root);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x    = '0;
            query_y    = '0;
            query_z    = '0;
            query_w    = '0;
            best_sq    = '1;
            fail_count = 0;
            run_min_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_QUERY_X: query_x = cfg_data;
                    REG_QUERY_Y: query_y = cfg_data;
                    REG_QUERY_Z: query_z = cfg_data;
                    REG_QUERY_W: query_w = cfg_data;
                    default: ;
                endcase
            end

            if (pop && !empty)
            begin
                if (run_min_due.size() == 0)
                begin
                    $display("%0t: unexpected result min_sq=%0d min_dist=%0d",
                             $time, result.min_sq, result.min_dist);
                    fail_count++;
                end
                else
                begin
                    due = run_min_due.pop_front();
                    if (result.min_sq !== due.min_sq)
                    begin
                        $display("%0t: min_sq expected %0d actual %0d",
                                 $time, due.min_sq, result.min_sq);
                        fail_count++;
                    end
                    if (result.min_dist !== due.min_dist)
                    begin
                        $display("%0t: min_dist expected %0d actual %0d",
                                 $time, due.min_dist, result.min_dist);
                        fail_count++;
                    end
                end
            end

            // A first point reloads the minimum from its prior, others continue.
            if (push && !full)
            begin
                cand_sq = point_dist_sq(point);
                keep_sq = point.first_point ? point.prior_min_sq : best_sq;
                if (cand_sq < keep_sq)
                    keep_sq = cand_sq;
                best_sq = keep_sq;
                if (point.last_point)
                begin
                    due.min_sq   = keep_sq;
                    due.min_dist = isqrt_floor(keep_sq);
                    run_min_due.push_back(due);
                end
            end
        end
        pending = run_min_due.size();
    end

endmodule

// ===== tb/leaf_min_distance_reduce_test.sv =====
// ============================================================================
// leaf_min_distance_reduce_test
// Drives query writes and leaf point runs into the nearest-distance reduce
// under several idle and stall mixes; the checker judges every result.
// ============================================================================
module leaf_min_distance_reduce_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lmdr_pkg::*;

    // Index outside the query block; writes to it must leave the query alone.
    localparam cfg_index_t REG_UNMAPPED = cfg_index_t'(8'hFC);
    // Pipeline depth after the last expected result, with margin.
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 108;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    coord_t     cfg_data;
    logic       push;
    logic       full;
    point_t     point;
    logic       empty;
    logic       pop;
    result_t    result;
    int         fail_count;
    int         pending;

    // Percent chance per cycle that the sender holds off / the receiver stalls.
    int         idle_pct;
    int         stall_pct;
    // Query currently programmed, used to aim random points close to it.
    coord_t     query_now [4];

    int idle_plan  [4] = '{0, 77, 0, 6};
    int stall_plan [4] = '{0, 0, 77, 6};

    leaf_min_distance_reduce u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .point     (point),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    leaf_min_distance_reduce_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .point      (point),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #2_000_000;
        $display("FAIL leaf_min_distance_reduce");
        $finish;
    end

    // Receiver: decide each cycle at the falling edge whether to take a result.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Write one register; hold valid until the write is taken, then drop it.
    task automatic write_reg(cfg_index_t idx, coord_t data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_query(coord_t x, coord_t y, coord_t z, coord_t w);
        write_reg(REG_QUERY_X, x);
        write_reg(REG_QUERY_Y, y);
        write_reg(REG_QUERY_Z, z);
        write_reg(REG_QUERY_W, w);
        query_now = '{x, y, z, w};
    endtask

    // Send one point request, with random hold-off ahead of it. Push stays
    // high afterwards so back-to-back points go one per cycle while full is low.
    task automatic send_point(point_t p);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push  = 1'b1;
        point = p;
        do
            @(posedge clk);
        while (full);
    endtask

    // Drop push, wait for every expected result, then let points that make
    // no result leave the pipeline before the query changes.
    task automatic settle_idle();
        @(negedge clk);
        push = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic point_t make_point(coord_t x, coord_t y, coord_t z, coord_t w,
                                          sq_t prior, logic first, logic last);
        point_t p;
        p.point_x      = x;
        p.point_y      = y;
        p.point_z      = z;
        p.point_w      = w;
        p.prior_min_sq = prior;
        p.first_point  = first;
        p.last_point   = last;
        return p;
    endfunction

    // Mix rails, near-query values (small distances) and full-range values.
    function automatic coord_t rand_coord(coord_t q);
        int v;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3:
            begin
                v = int'(q) + int'($urandom_range(0, 128)) - 64;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return coord_t'(v);
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Prior: none (all ones), zero, small, full random, or above the
    // largest reachable distance.
    function automatic sq_t rand_prior();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return sq_t'($urandom_range(0, 4096));
            5: return sq_t'(34'd17179344900) + sq_t'($urandom_range(1, 524283));
            default: return sq_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic point_t rand_point(logic first, logic last);
        return make_point(rand_coord(query_now[0]), rand_coord(query_now[1]),
                          rand_coord(query_now[2]), rand_coord(query_now[3]),
                          rand_prior(), first, last);
    endfunction

    // Mostly well-formed runs of 1..6 points; the rest are loose points with
    // random marks (missing first, missing last, stray first mid-run).
    task automatic random_runs(int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                send_point(rand_point(1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
                sent++;
            end
            else
            begin
                run_len = $urandom_range(1, 6);
                for (int i = 0; i < run_len; i++)
                    send_point(rand_point(i == 0, i == run_len - 1));
                sent += run_len;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_QUERY_X;
        cfg_data  = '0;
        push      = 1'b0;
        point     = '0;
        idle_pct  = 0;
        stall_pct = 0;
        query_now = '{default: '0};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Query at its reset value of zero.
        // No first mark right after reset: continue from the all-ones minimum.
        send_point(make_point('1, '1, '1, '1, '0, 1'b0, 1'b1));
        // Single-point run at the origin.
        send_point(make_point('0, '0, '0, '0, '1, 1'b1, 1'b1));
        // Three-point run, middle point wins (3-4-0-0 gives 25).
        send_point(make_point(16'd10, '0, '0, '0, '1, 1'b1, 1'b0));
        send_point(make_point(16'd3, 16'd4, '0, '0, '0, 1'b0, 1'b0));
        send_point(make_point('1, '1, '1, '1, '0, 1'b0, 1'b1));
        // After a last point the minimum is kept for an unmarked point.
        send_point(make_point('1, '1, '1, '1, '0, 1'b0, 1'b1));
        // Prior above range, every point smaller.
        send_point(make_point('1, '1, '1, '1, '1, 1'b1, 1'b1));
        send_point(make_point('1, '1, '1, '1, sq_t'(34'd17179344901), 1'b1, 1'b1));
        // Prior of zero beats any point.
        send_point(make_point(16'd1, 16'd1, 16'd1, 16'd1, '0, 1'b1, 1'b1));
        // Small prior survives the whole run.
        send_point(make_point(16'd100, 16'd1, '0, '0, sq_t'(7), 1'b1, 1'b0));
        send_point(make_point(16'd50, '0, '0, '0, '1, 1'b0, 1'b1));
        // A second first mark reloads the minimum mid-run.
        send_point(make_point(16'd1, 16'd1, 16'd1, 16'd1, sq_t'(1000), 1'b1, 1'b0));
        send_point(make_point(16'd2, 16'd2, 16'd2, 16'd2, sq_t'(9), 1'b1, 1'b1));
        settle_idle();

        // Query at the top rail; a stray write to an unmapped index must not
        // disturb it.
        write_query('1, '1, '1, '1);
        write_reg(REG_UNMAPPED, 16'h1234);
        send_point(make_point('0, '0, '0, '0, '1, 1'b1, 1'b1));
        send_point(make_point('1, '1, '1, '1, '1, 1'b1, 1'b1));
        send_point(make_point('0, '1, '0, '1, '1, 1'b1, 1'b1));
        send_point(make_point(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, '1, 1'b1, 1'b1));
        settle_idle();

        // Random phases, each under its own idle/stall mix and query.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_plan[ph];
            stall_pct = stall_plan[ph];
            case (ph)
                1: write_query('0, '1, '0, '1);
                3: write_query('1, '0, '1, '0);
                default: write_query(coord_t'($urandom), coord_t'($urandom),
                                     coord_t'($urandom), coord_t'($urandom));
            endcase
            random_runs(PHASE_ITEMS);
            settle_idle();
        end

        if (fail_count == 0)
            $display("PASS leaf_min_distance_reduce");
        else
            $display("FAIL leaf_min_distance_reduce");
        $finish;
    end

endmodule

// ===== leaf_min_distance_reduce.f =====
+incdir+src
src/lmdr_pkg.sv
src/lmdr_front.sv
src/lmdr_queue.sv
src/lmdr_back.sv
src/leaf_min_distance_reduce.sv
tb/leaf_min_distance_reduce_checker.sv
tb/leaf_min_distance_reduce_test.sv
